FILE: rtl/bfb_pkg.sv
// Shared types, constants and defaults for the bitmap font text blitter.
package bfb_pkg;

    // Field widths fixed by the item format
    localparam int CMD_W    = 2;
    localparam int CODE_W   = 8;
    localparam int TAG_W    = 8;
    localparam int OFF_W    = 12;
    localparam int GW_W     = 4;
    localparam int CADDR_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int HEIGHT_W = 4;

    localparam int GLYPHS   = 256;

    // Parameter defaults
    localparam int DEF_FONT_CELLS       = 4096;
    localparam int DEF_MAX_GLYPH_WIDTH  = 8;
    localparam int DEF_MAX_GLYPH_HEIGHT = 8;

    // Configuration space
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_FONT_HEIGHT = 2'd0;
    localparam logic [HEIGHT_W-1:0] FONT_HEIGHT_RST = 4'd8;

    localparam logic [BYTE_W-1:0] CELL_ON = 8'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_GLYPH = 2'd0,
        CMD_CELL  = 2'd1,
        CMD_START = 2'd2,
        CMD_DRAW  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOOK  = 5'b00010,
        ST_WRAP  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [OFF_W-1:0] offset;
        logic [GW_W-1:0]  width;
    } glyph_entry_t;

endpackage

FILE: rtl/bfb_if.sv
// Valid/ready channel interfaces for commands in and pixel writes out.
interface bfb_cmd_if
    import bfb_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CODE_W-1:0]    char_code;
    logic [TAG_W-1:0]     glyph_tag;
    logic [OFF_W-1:0]     glyph_offset;
    logic [GW_W-1:0]      glyph_width;
    logic [CADDR_W-1:0]   cell_address;
    logic [BYTE_W-1:0]    cell_byte;
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COLOR_W-1:0]   ink_color;

    modport source (
        output valid, command, char_code, glyph_tag, glyph_offset, glyph_width,
               cell_address, cell_byte, start_x, start_y, ink_color,
        input  ready
    );
    modport sink (
        input  valid, command, char_code, glyph_tag, glyph_offset, glyph_width,
               cell_address, cell_byte, start_x, start_y, ink_color,
        output ready
    );
endinterface

interface bfb_pix_if
    import bfb_pkg::*;
    ();
    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   pixel_x;
    logic [COORD_W-1:0]   pixel_y;
    logic [COLOR_W-1:0]   pixel_color;
    logic                 last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

FILE: rtl/bitmap_font_text_blitter.sv
// Top level of the bitmap font text blitter: glyph table, font store and scan engine.
//
// Renders text from a variable-width bitmap font. Commands arrive one transfer at a
// time on req: write a glyph table entry (tag, cell offset, width saturated to
// MAX_GLYPH_WIDTH), write one font cell (set only when cell_byte is exactly 1; addresses
// at or above FONT_CELLS are dropped), start a text run (pen position and ink color), or
// draw a character. A draw looks the glyph up; if the stored tag equals the character
// code and the offset is nonzero, the glyph's rows x columns of font cells are scanned
// from the offset (wrapping modulo FONT_CELLS) and one pixel transfer goes out on pix for
// each set cell, last_pixel marking the final one. The pen x always advances by the
// glyph width plus one, coordinates wrap at 16 bits and no clipping is done. The glyph
// table is 256 entries in a synchronous RAM with one valid flop per entry (so it reads
// as all-zero after reset, no clearing pass); the font store is a 1-bit synchronous RAM
// of FONT_CELLS entries with no reset, so unwritten cells must not be drawn.
// Sequence: glyph, cell and start commands complete when accepted. A draw registers the
// glyph table read and LOOK returns to idle for an absent or empty glyph; a drawn glyph
// goes on through WRAP, which brings the offset into the store by repeated subtraction of
// FONT_CELLS, then SCAN, which reads one cell per cycle (rows x width, up to 64 at the
// defaults) unless the pixel output stalls, then DRAIN, which flushes, all bounded by the
// single font store read port. The pix output is registered with a one-pixel hold stage,
// so scanning continues while a pixel waits; a stalled sink stops the scan only when both
// are full. font_height is to be written over the APB port (address 0) only while the
// block is idle; the block itself does not enforce this. pready is always high.
module bitmap_font_text_blitter
    import bfb_pkg::*;
#(
    parameter int FONT_CELLS       = DEF_FONT_CELLS,
    parameter int MAX_GLYPH_WIDTH  = DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = DEF_MAX_GLYPH_HEIGHT
)(
    input  logic                clk,
    input  logic                rst_n,
    bfb_cmd_if.sink             req,
    bfb_pix_if.source           pix,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW    = $clog2(FONT_CELLS);
    localparam int CNT_W = $clog2(FONT_CELLS + 1);
    localparam int CMP_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;
    localparam logic [CMP_W-1:0]    CELLS_C   = CMP_W'(FONT_CELLS);
    localparam logic [AW-1:0]       ADDR_TOP  = AW'(FONT_CELLS - 1);
    localparam logic [GW_W-1:0]     MAX_W_C   = GW_W'(MAX_GLYPH_WIDTH);
    localparam logic [HEIGHT_W-1:0] MAX_H_C   = HEIGHT_W'(MAX_GLYPH_HEIGHT);

    // ---------------- configuration ----------------
    logic [HEIGHT_W-1:0] font_height_reg;

    assign pready = 1'b1;
    assign prdata = PDATA_W'(font_height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_height_reg <= FONT_HEIGHT_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_FONT_HEIGHT)
        begin
            font_height_reg <= pwdata[HEIGHT_W-1:0];
        end
    end

    // ---------------- control state ----------------
    state_t               state_reg, state_next;
    logic [COORD_W-1:0]   pen_x_reg, pen_x_next;
    logic [COORD_W-1:0]   pen_y_reg;
    logic [COLOR_W-1:0]   pen_color_reg;
    logic [CODE_W-1:0]    code_reg;
    logic [GW_W-1:0]      width_reg, width_next;
    logic [HEIGHT_W-1:0]  h_reg, h_next;
    logic [CMP_W-1:0]     off_reg, off_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [GW_W-1:0]      col_reg, col_next;
    logic [HEIGHT_W-1:0]  row_reg, row_next;
    logic                 p1_valid_reg, p1_valid_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 pix_valid_reg, pix_valid_next;

    // payload registers
    logic [COORD_W-1:0]   p1_x_reg, p1_y_reg;
    logic [COORD_W-1:0]   hold_x_reg, hold_y_reg;
    logic [COORD_W-1:0]   pix_x_reg, pix_y_reg;
    logic [COLOR_W-1:0]   pix_color_reg;
    logic                 pix_last_reg;

    // memories
    glyph_entry_t         glyph_mem [GLYPHS];
    logic [GLYPHS-1:0]    glyph_vld_reg;
    glyph_entry_t         glyph_q;
    logic                 glyph_vld_q;
    logic                 font_mem [FONT_CELLS];
    logic                 font_q;

    // ---------------- handshake and decode ----------------
    logic                 accept;
    logic                 glyph_we, cell_we, start_we, draw_go;
    logic [GW_W-1:0]      sat_width;
    glyph_entry_t         entry;
    logic                 hit;
    logic [HEIGHT_W-1:0]  h_eff;
    logic                 slot_free, cell_set, adv, issue;
    logic                 push_mid, push_end, scan_last;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign glyph_we  = accept && req.command == CMD_GLYPH;
    assign cell_we   = accept && req.command == CMD_CELL
                       && CMP_W'(req.cell_address) < CELLS_C;
    assign start_we  = accept && req.command == CMD_START;
    assign draw_go   = accept && req.command == CMD_DRAW;
    assign sat_width = (req.glyph_width > MAX_W_C) ? MAX_W_C : req.glyph_width;

    // Lookup result; an entry never written reads as all zero (glyph absent)
    assign entry = glyph_vld_q ? glyph_q : '0;
    assign hit   = (entry.tag == code_reg) && (entry.offset != '0);
    assign h_eff = (font_height_reg > MAX_H_C) ? MAX_H_C : font_height_reg;

    // Scan pipeline: issue stage reads a cell, next stage checks it. A found pixel
    // moves into the hold stage; the held one goes out only once a later pixel proves
    // it is not the last, or the scan ends.
    assign slot_free = !pix_valid_reg || pix.ready;
    assign cell_set  = p1_valid_reg && font_q;
    assign adv       = !(cell_set && hold_valid_reg && !slot_free);
    assign issue     = (state_reg == ST_SCAN) && adv;
    assign push_mid  = adv && cell_set && hold_valid_reg;
    assign push_end  = (state_reg == ST_DRAIN) && !p1_valid_reg && hold_valid_reg
                       && slot_free;
    assign scan_last = (col_reg == width_reg - GW_W'(1))
                       && (row_reg == h_reg - HEIGHT_W'(1));

    always_comb
    begin
        state_next      = state_reg;
        pen_x_next      = pen_x_reg;
        width_next      = width_reg;
        h_next          = h_reg;
        off_next        = off_reg;
        addr_next       = addr_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        p1_valid_next   = adv ? issue : p1_valid_reg;
        hold_valid_next = hold_valid_reg;
        pix_valid_next  = pix_valid_reg && !pix.ready;

        if (adv && cell_set)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_end)
        begin
            hold_valid_next = 1'b0;
        end
        if (push_mid || push_end)
        begin
            pix_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start_we)
                begin
                    pen_x_next = req.start_x;
                end
                if (draw_go)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                width_next = entry.width;
                h_next     = h_eff;
                off_next   = CMP_W'(entry.offset);
                if (hit && h_eff != '0 && entry.width != '0)
                begin
                    state_next = ST_WRAP;
                end
                else
                begin
                    pen_x_next = pen_x_reg + COORD_W'(entry.width) + COORD_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_WRAP:
            begin
                // offset modulo store size, one subtraction per cycle
                if (off_reg >= CELLS_C)
                begin
                    off_next = off_reg - CELLS_C;
                end
                else
                begin
                    addr_next  = off_reg[AW-1:0];
                    col_next   = '0;
                    row_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    addr_next = (addr_reg == ADDR_TOP) ? '0 : addr_reg + AW'(1);
                    if (scan_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else if (col_reg == width_reg - GW_W'(1))
                    begin
                        col_next = '0;
                        row_next = row_reg + HEIGHT_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + GW_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && (!hold_valid_reg || slot_free))
                begin
                    pen_x_next = pen_x_reg + COORD_W'(width_reg) + COORD_W'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            pen_color_reg  <= '0;
            width_reg      <= '0;
            h_reg          <= '0;
            off_reg        <= '0;
            addr_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            p1_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            pix_valid_reg  <= 1'b0;
            glyph_vld_reg  <= '0;
            code_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pen_x_reg      <= pen_x_next;
            width_reg      <= width_next;
            h_reg          <= h_next;
            off_reg        <= off_next;
            addr_reg       <= addr_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            p1_valid_reg   <= p1_valid_next;
            hold_valid_reg <= hold_valid_next;
            pix_valid_reg  <= pix_valid_next;
            if (start_we)
            begin
                pen_y_reg     <= req.start_y;
                pen_color_reg <= req.ink_color;
            end
            if (glyph_we)
            begin
                glyph_vld_reg[req.char_code] <= 1'b1;
            end
            if (draw_go)
            begin
                code_reg <= req.char_code;
            end
        end
    end

    // ---------------- glyph table RAM ----------------
    always_ff @(posedge clk)
    begin
        if (glyph_we)
        begin
            glyph_mem[req.char_code] <= '{tag: req.glyph_tag, offset: req.glyph_offset,
                                          width: sat_width};
        end
        if (draw_go)
        begin
            glyph_q     <= glyph_mem[req.char_code];
            glyph_vld_q <= glyph_vld_reg[req.char_code];
        end
    end

    // ---------------- font cell RAM ----------------
    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            font_mem[AW'(req.cell_address)] <= (req.cell_byte == CELL_ON);
        end
        if (issue)
        begin
            font_q <= font_mem[addr_reg];
        end
    end

    // ---------------- scan datapath ----------------
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_x_reg <= pen_x_reg + COORD_W'(col_reg);
            p1_y_reg <= pen_y_reg + COORD_W'(row_reg);
        end
        if (adv && cell_set)
        begin
            hold_x_reg <= p1_x_reg;
            hold_y_reg <= p1_y_reg;
        end
        if (push_mid || push_end)
        begin
            pix_x_reg     <= hold_x_reg;
            pix_y_reg     <= hold_y_reg;
            pix_color_reg <= pen_color_reg;
            pix_last_reg  <= push_end;
        end
    end

    assign pix.valid       = pix_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_color = pix_color_reg;
    assign pix.last_pixel  = pix_last_reg;

endmodule
